@@ hdl/gps_pkg.sv @@
package gps_pkg;

  localparam int MAX_SEGMENTS = 256;
  localparam int MAX_HORIZON  = 64;

  localparam int ITER_W     = 32;
  localparam int SEG_W      = 9;
  localparam int POS_W      = 8;
  localparam int STEP_W     = 6;
  localparam int LEN_W      = 7;
  localparam int FRAC_W     = 16;
  localparam int FRAC_SHIFT = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // serial divider: dividend is left aligned, one quotient bit per cycle
  localparam int DIV_W      = 32;
  localparam int CNT_W      = 6;
  localparam int FRAC_STEPS = POS_W + FRAC_SHIFT;
  localparam int OFS_PAD_W  = DIV_W - POS_W;
  localparam int STR_PAD_W  = DIV_W - SEG_W;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_SEGMENTS   = 3'd0,
    REG_OFFSET_LEFT    = 3'd1,
    REG_OFFSET_RIGHT   = 3'd2,
    REG_DURATION_LEFT  = 3'd3,
    REG_DURATION_RIGHT = 3'd4,
    REG_HORIZON_LENGTH = 3'd5,
    REG_HORIZON_STRIDE = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [SEG_W-1:0] num_segments;
    logic [POS_W-1:0] offset_left;
    logic [POS_W-1:0] offset_right;
    logic [SEG_W-1:0] duration_left;
    logic [SEG_W-1:0] duration_right;
    logic [LEN_W-1:0] horizon_length;
    logic [SEG_W-1:0] horizon_stride;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] steps;
    logic [DIV_W-1:0] dividend;
    logic [SEG_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
    logic [SEG_W-1:0] rem;
  } div_rsp_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_PUSH
  } fr_state_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MOD,
    BK_LOAD,
    BK_FRAC,
    BK_STRIDE,
    BK_EMIT
  } bk_state_t;

  // zero counts as one, large counts saturate
  function automatic logic [SEG_W-1:0] seg_count(input logic [SEG_W-1:0] num);
    if (num == '0) begin
      return SEG_W'(1);
    end else if (num > SEG_W'(MAX_SEGMENTS)) begin
      return SEG_W'(MAX_SEGMENTS);
    end else begin
      return num;
    end
  endfunction

  // distance from a leg's stance start, wrapped into [0, n)
  function automatic logic [POS_W-1:0] progress(input logic [POS_W-1:0] pos,
                                                input logic [POS_W-1:0] ofs,
                                                input logic [SEG_W-1:0] n);
    logic [SEG_W-1:0] t;
    if (pos >= ofs) begin
      t = {1'b0, pos} - {1'b0, ofs};
    end else begin
      t = {1'b0, pos} + n - {1'b0, ofs};
    end
    return t[POS_W-1:0];
  endfunction

  function automatic logic [STEP_W-1:0] last_step(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] l;
    l = len;
    if (l == '0) begin
      l = LEN_W'(1);
    end
    if (l > LEN_W'(MAX_HORIZON)) begin
      l = LEN_W'(MAX_HORIZON);
    end
    return STEP_W'(l - LEN_W'(1));
  endfunction

endpackage

@@ hdl/biped_gait_phase_scheduler_core.sv @@
// Gait phase scheduler. Each input word carries an iteration count; the block
// reduces it modulo the segment count, works out each leg's stance or swing
// fraction (Q1.15) and then sends one result word per horizon step with the
// predicted contact of both legs, the final word flagged by out_last. A front
// stage takes the input word and reduces it in a serial divider and accepts no
// new word until its segment is pushed; a two-entry queue hands segments
// to the back stage, which runs two serial dividers in parallel for the
// offsets and the fractions, then one for the stride, and then emits one
// result per cycle while the output is taken. It takes no new segment until
// it has emitted the final result word for the segment before.
// Configuration writes are taken every cycle and must only occur while idle.
module biped_gait_phase_scheduler_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gps_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [gps_pkg::ITER_W-1:0]     in_iteration,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [gps_pkg::STEP_W-1:0]     out_step_index,
  output logic                           out_contact_left,
  output logic                           out_contact_right,
  output logic [gps_pkg::FRAC_W-1:0]     out_stance_left,
  output logic [gps_pkg::FRAC_W-1:0]     out_stance_right,
  output logic [gps_pkg::FRAC_W-1:0]     out_swing_left,
  output logic [gps_pkg::FRAC_W-1:0]     out_swing_right,
  output logic [gps_pkg::POS_W-1:0]      out_current_segment,
  output logic                           out_last
);

  gps_pkg::cfg_t             cfg_r;
  logic                      push_valid, push_ready, pop_valid, pop_ready;
  logic [gps_pkg::POS_W-1:0] push_data, pop_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_segments   <= gps_pkg::SEG_W'(16);
      cfg_r.offset_left    <= gps_pkg::POS_W'(0);
      cfg_r.offset_right   <= gps_pkg::POS_W'(8);
      cfg_r.duration_left  <= gps_pkg::SEG_W'(8);
      cfg_r.duration_right <= gps_pkg::SEG_W'(8);
      cfg_r.horizon_length <= gps_pkg::LEN_W'(10);
      cfg_r.horizon_stride <= gps_pkg::SEG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gps_pkg::REG_NUM_SEGMENTS:   cfg_r.num_segments   <= cfg_data;
        gps_pkg::REG_OFFSET_LEFT:    cfg_r.offset_left    <= cfg_data[gps_pkg::POS_W-1:0];
        gps_pkg::REG_OFFSET_RIGHT:   cfg_r.offset_right   <= cfg_data[gps_pkg::POS_W-1:0];
        gps_pkg::REG_DURATION_LEFT:  cfg_r.duration_left  <= cfg_data;
        gps_pkg::REG_DURATION_RIGHT: cfg_r.duration_right <= cfg_data;
        gps_pkg::REG_HORIZON_LENGTH: cfg_r.horizon_length <= cfg_data[gps_pkg::LEN_W-1:0];
        gps_pkg::REG_HORIZON_STRIDE: cfg_r.horizon_stride <= cfg_data;
        default: ;
      endcase
    end
  end

  gps_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_iteration (in_iteration),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_data    (push_data)
  );

  gps_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  gps_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .pop_valid           (pop_valid),
    .pop_ready           (pop_ready),
    .pop_data            (pop_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_step_index      (out_step_index),
    .out_contact_left    (out_contact_left),
    .out_contact_right   (out_contact_right),
    .out_stance_left     (out_stance_left),
    .out_stance_right    (out_stance_right),
    .out_swing_left      (out_swing_left),
    .out_swing_right     (out_swing_right),
    .out_current_segment (out_current_segment),
    .out_last            (out_last)
  );

endmodule

@@ hdl/gps_div.sv @@
module gps_div (
  input  logic               clk,
  input  logic               rst_n,
  input  gps_pkg::div_req_t  req,
  output gps_pkg::div_rsp_t  rsp
);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [gps_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [gps_pkg::DIV_W-1:0]   dvd_r, dvd_nxt;
  logic [gps_pkg::DIV_W-1:0]   quo_r, quo_nxt;
  logic [gps_pkg::SEG_W-1:0]   rem_r, rem_nxt;
  logic [gps_pkg::SEG_W-1:0]   dsr_r, dsr_nxt;
  logic [gps_pkg::SEG_W:0]     trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    trial    = {rem_r, dvd_r[gps_pkg::DIV_W-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.steps;
      dvd_nxt  = req.dividend;
      quo_nxt  = '0;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = gps_pkg::SEG_W'(trial - {1'b0, dsr_r});
        quo_nxt = {quo_r[gps_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[gps_pkg::SEG_W-1:0];
        quo_nxt = {quo_r[gps_pkg::DIV_W-2:0], 1'b0};
      end
      dvd_nxt = {dvd_r[gps_pkg::DIV_W-2:0], 1'b0};
      cnt_nxt = cnt_r - gps_pkg::CNT_W'(1);
      if (cnt_r == gps_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

@@ hdl/gps_fifo.sv @@
module gps_fifo (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push_valid,
  output logic                      push_ready,
  input  logic [gps_pkg::POS_W-1:0] push_data,
  output logic                      pop_valid,
  input  logic                      pop_ready,
  output logic [gps_pkg::POS_W-1:0] pop_data
);

  logic [gps_pkg::POS_W-1:0]      mem_r [gps_pkg::FIFO_DEPTH];
  logic [gps_pkg::FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [gps_pkg::FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [gps_pkg::FIFO_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                           do_push, do_pop;

  assign push_ready = (cnt_r != gps_pkg::FIFO_CNT_W'(gps_pkg::FIFO_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + gps_pkg::FIFO_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + gps_pkg::FIFO_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + gps_pkg::FIFO_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - gps_pkg::FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ hdl/gps_front.sv @@
module gps_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  gps_pkg::cfg_t              cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [gps_pkg::ITER_W-1:0] in_iteration,
  output logic                       push_valid,
  input  logic                       push_ready,
  output logic [gps_pkg::POS_W-1:0]  push_data
);

  gps_pkg::fr_state_t state_r, state_nxt;
  gps_pkg::div_req_t  div_req;
  gps_pkg::div_rsp_t  div_rsp;

  gps_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gps_pkg::FR_IDLE: begin
        if (in_valid) begin
          state_nxt = gps_pkg::FR_DIV;
        end
      end
      gps_pkg::FR_DIV: begin
        if (div_rsp.done) begin
          state_nxt = gps_pkg::FR_PUSH;
        end
      end
      gps_pkg::FR_PUSH: begin
        if (push_ready) begin
          state_nxt = gps_pkg::FR_IDLE;
        end
      end
      default: state_nxt = gps_pkg::FR_IDLE;
    endcase
  end

  // segment = iteration mod n, remainder held by the divider until the next start
  always_comb begin
    in_ready         = (state_r == gps_pkg::FR_IDLE);
    push_valid       = (state_r == gps_pkg::FR_PUSH);
    push_data        = div_rsp.rem[gps_pkg::POS_W-1:0];
    div_req.start    = in_valid && in_ready;
    div_req.steps    = gps_pkg::CNT_W'(gps_pkg::ITER_W);
    div_req.dividend = in_iteration;
    div_req.divisor  = gps_pkg::seg_count(cfg.num_segments);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gps_pkg::FR_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hdl/gps_back.sv @@
module gps_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  gps_pkg::cfg_t              cfg,
  input  logic                       pop_valid,
  output logic                       pop_ready,
  input  logic [gps_pkg::POS_W-1:0]  pop_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [gps_pkg::STEP_W-1:0] out_step_index,
  output logic                       out_contact_left,
  output logic                       out_contact_right,
  output logic [gps_pkg::FRAC_W-1:0] out_stance_left,
  output logic [gps_pkg::FRAC_W-1:0] out_stance_right,
  output logic [gps_pkg::FRAC_W-1:0] out_swing_left,
  output logic [gps_pkg::FRAC_W-1:0] out_swing_right,
  output logic [gps_pkg::POS_W-1:0]  out_current_segment,
  output logic                       out_last
);

  gps_pkg::bk_state_t state_r, state_nxt;
  gps_pkg::div_req_t  req_lt, req_rt;
  gps_pkg::div_rsp_t  rsp_lt, rsp_rt;

  logic [gps_pkg::POS_W-1:0]  cur_r, ofs_lt_r, ofs_rt_r, stride_r, pos_r;
  logic [gps_pkg::STEP_W-1:0] step_r;
  logic                       lt_stance_r, rt_stance_r, lt_zero_r, rt_zero_r;
  logic [gps_pkg::FRAC_W-1:0] st_lt_r, st_rt_r, sw_lt_r, sw_rt_r;
  logic                       out_valid_r;
  logic [gps_pkg::STEP_W-1:0] out_step_r;
  logic                       out_cl_r, out_cr_r, out_last_r;
  logic [gps_pkg::FRAC_W-1:0] out_stl_r, out_str_r, out_swl_r, out_swr_r;
  logic [gps_pkg::POS_W-1:0]  out_seg_r;

  logic [gps_pkg::SEG_W-1:0]  n;
  logic [gps_pkg::POS_W-1:0]  p_lt, p_rt, num_lt, num_rt, pe_lt, pe_rt;
  logic                       in_st_lt, in_st_rt;
  logic [gps_pkg::SEG_W-1:0]  pos_first, pos_sum;
  logic [gps_pkg::STEP_W-1:0] last_idx;
  logic                       both_done, out_free, emit;

  gps_div u_div_lt (.clk(clk), .rst_n(rst_n), .req(req_lt), .rsp(rsp_lt));
  gps_div u_div_rt (.clk(clk), .rst_n(rst_n), .req(req_rt), .rsp(rsp_rt));

  always_comb begin
    n         = gps_pkg::seg_count(cfg.num_segments);
    last_idx  = gps_pkg::last_step(cfg.horizon_length);
    both_done = rsp_lt.done && rsp_rt.done;
    out_free  = !out_valid_r || out_ready;
    // progress at the current segment, stance when at most the duration
    p_lt      = gps_pkg::progress(cur_r, ofs_lt_r, n);
    p_rt      = gps_pkg::progress(cur_r, ofs_rt_r, n);
    in_st_lt  = ({1'b0, p_lt} <= cfg.duration_left);
    in_st_rt  = ({1'b0, p_rt} <= cfg.duration_right);
    num_lt    = in_st_lt ? p_lt : gps_pkg::POS_W'({1'b0, p_lt} - cfg.duration_left);
    num_rt    = in_st_rt ? p_rt : gps_pkg::POS_W'({1'b0, p_rt} - cfg.duration_right);
    // horizon walk
    pos_first = {1'b0, cur_r} + gps_pkg::SEG_W'(1);
    if (pos_first == n) begin
      pos_first = '0;
    end
    pos_sum = {1'b0, pos_r} + {1'b0, stride_r};
    if (pos_sum >= n) begin
      pos_sum = pos_sum - n;
    end
    pe_lt = gps_pkg::progress(pos_r, ofs_lt_r, n);
    pe_rt = gps_pkg::progress(pos_r, ofs_rt_r, n);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gps_pkg::BK_IDLE: begin
        if (pop_valid) begin
          state_nxt = gps_pkg::BK_MOD;
        end
      end
      gps_pkg::BK_MOD: begin
        if (both_done) begin
          state_nxt = gps_pkg::BK_LOAD;
        end
      end
      gps_pkg::BK_LOAD: state_nxt = gps_pkg::BK_FRAC;
      gps_pkg::BK_FRAC: begin
        if (both_done) begin
          state_nxt = gps_pkg::BK_STRIDE;
        end
      end
      gps_pkg::BK_STRIDE: begin
        if (rsp_lt.done) begin
          state_nxt = gps_pkg::BK_EMIT;
        end
      end
      gps_pkg::BK_EMIT: begin
        if (out_free && step_r == last_idx) begin
          state_nxt = gps_pkg::BK_IDLE;
        end
      end
      default: state_nxt = gps_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop_ready       = 1'b0;
    emit            = 1'b0;
    req_lt.start    = 1'b0;
    req_lt.steps    = gps_pkg::CNT_W'(gps_pkg::POS_W);
    req_lt.dividend = {cfg.offset_left, gps_pkg::OFS_PAD_W'(0)};
    req_lt.divisor  = n;
    req_rt.start    = 1'b0;
    req_rt.steps    = gps_pkg::CNT_W'(gps_pkg::POS_W);
    req_rt.dividend = {cfg.offset_right, gps_pkg::OFS_PAD_W'(0)};
    req_rt.divisor  = n;
    case (state_r)
      gps_pkg::BK_IDLE: begin
        pop_ready    = 1'b1;
        req_lt.start = pop_valid;
        req_rt.start = pop_valid;
      end
      gps_pkg::BK_LOAD: begin
        // (p << 15) / d in stance, ((p - d) << 15) / (n - d) in swing
        req_lt.start    = 1'b1;
        req_lt.steps    = gps_pkg::CNT_W'(gps_pkg::FRAC_STEPS);
        req_lt.dividend = {num_lt, gps_pkg::OFS_PAD_W'(0)};
        req_lt.divisor  = in_st_lt ? cfg.duration_left : n - cfg.duration_left;
        req_rt.start    = 1'b1;
        req_rt.steps    = gps_pkg::CNT_W'(gps_pkg::FRAC_STEPS);
        req_rt.dividend = {num_rt, gps_pkg::OFS_PAD_W'(0)};
        req_rt.divisor  = in_st_rt ? cfg.duration_right : n - cfg.duration_right;
      end
      gps_pkg::BK_FRAC: begin
        req_lt.start    = both_done;
        req_lt.steps    = gps_pkg::CNT_W'(gps_pkg::SEG_W);
        req_lt.dividend = {cfg.horizon_stride, gps_pkg::STR_PAD_W'(0)};
      end
      gps_pkg::BK_EMIT: begin
        emit = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gps_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == gps_pkg::BK_IDLE && pop_valid) begin
      cur_r <= pop_data;
    end
    if (state_r == gps_pkg::BK_MOD && both_done) begin
      ofs_lt_r <= rsp_lt.rem[gps_pkg::POS_W-1:0];
      ofs_rt_r <= rsp_rt.rem[gps_pkg::POS_W-1:0];
    end
    if (state_r == gps_pkg::BK_LOAD) begin
      lt_stance_r <= in_st_lt;
      rt_stance_r <= in_st_rt;
      lt_zero_r   <= (cfg.duration_left == '0);
      rt_zero_r   <= (cfg.duration_right == '0);
    end
    if (state_r == gps_pkg::BK_FRAC && both_done) begin
      // zero duration: divider result is meaningless, fraction is 0
      st_lt_r <= (lt_stance_r && !lt_zero_r) ? rsp_lt.quo[gps_pkg::FRAC_W-1:0] : '0;
      sw_lt_r <= lt_stance_r ? '0 : rsp_lt.quo[gps_pkg::FRAC_W-1:0];
      st_rt_r <= (rt_stance_r && !rt_zero_r) ? rsp_rt.quo[gps_pkg::FRAC_W-1:0] : '0;
      sw_rt_r <= rt_stance_r ? '0 : rsp_rt.quo[gps_pkg::FRAC_W-1:0];
      pos_r   <= pos_first[gps_pkg::POS_W-1:0];
      step_r  <= '0;
    end
    if (state_r == gps_pkg::BK_STRIDE && rsp_lt.done) begin
      stride_r <= rsp_lt.rem[gps_pkg::POS_W-1:0];
    end
    if (emit) begin
      out_step_r <= step_r;
      out_cl_r   <= ({1'b0, pe_lt} < cfg.duration_left);
      out_cr_r   <= ({1'b0, pe_rt} < cfg.duration_right);
      out_stl_r  <= st_lt_r;
      out_str_r  <= st_rt_r;
      out_swl_r  <= sw_lt_r;
      out_swr_r  <= sw_rt_r;
      out_seg_r  <= cur_r;
      out_last_r <= (step_r == last_idx);
      pos_r      <= pos_sum[gps_pkg::POS_W-1:0];
      step_r     <= step_r + gps_pkg::STEP_W'(1);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_step_index      = out_step_r;
  assign out_contact_left    = out_cl_r;
  assign out_contact_right   = out_cr_r;
  assign out_stance_left     = out_stl_r;
  assign out_stance_right    = out_str_r;
  assign out_swing_left      = out_swl_r;
  assign out_swing_right     = out_swr_r;
  assign out_current_segment = out_seg_r;
  assign out_last            = out_last_r;

endmodule
